// ===== design/lpcp_pkg.sv =====
// Shared types and constants for the lidar point camera projector.
`default_nettype none
package lpcp_pkg;

  // Width of the intrinsic registers (focal length and principal point).
  localparam int INTR_BITS = 24;
  // Fraction bits of the intrinsics relative to whole pixels.
  localparam int INTR_FRAC = 8;
  // Width of the configuration register index.
  localparam int CFG_INDEX_BITS = 4;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FOCAL    = 4'd0,
    REG_CENTER_C = 4'd1,
    REG_CENTER_R = 4'd2,
    REG_LATERAL  = 4'd3,
    REG_DEPTH    = 4'd4,
    REG_VERTICAL = 4'd5,
    REG_WIDTH    = 4'd6,
    REG_HEIGHT   = 4'd7
  } lpcp_reg_t;

  // Control that travels beside the data through the division cells.
  typedef struct packed {
    logic valid;
    logic ok;
  } lpcp_ctl_t;

endpackage
`default_nettype wire

// ===== design/lpcp_front.sv =====
// Front stages: axis offsets, pinhole products, numerators and view test.
`default_nettype none
module lpcp_front
  import lpcp_pkg::*;
#(
  parameter int CB = 24,
  parameter int PB = 13,
  parameter int NW = INTR_BITS + CB + 3,
  parameter int DW = CB + 1 + INTR_FRAC,
  parameter int WW = NW + PB + 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic signed [CB-1:0] px,
  input  wire logic signed [CB-1:0] py,
  input  wire logic signed [CB-1:0] pz,
  input  wire logic [INTR_BITS-1:0] focal,
  input  wire logic [INTR_BITS-1:0] cen_c,
  input  wire logic [INTR_BITS-1:0] cen_r,
  input  wire logic signed [CB-1:0] off_lat,
  input  wire logic signed [CB-1:0] off_dep,
  input  wire logic signed [CB-1:0] off_ver,
  input  wire logic [PB-1:0]        img_w,
  input  wire logic [PB-1:0]        img_h,
  output lpcp_ctl_t                 ctl,
  output logic [NW-2:0]             num_c,
  output logic [NW-2:0]             num_r,
  output logic [DW-1:0]             dv
);

  localparam int PW = INTR_BITS + CB + 2;

  // stage 1: camera frame terms
  logic                 v1;
  logic signed [CB:0]   depth1, horiz1, vert1;
  // stage 2: products
  logic                 v2, pos2;
  logic signed [PW-1:0] pfc, pcc, pfr, pcr;
  logic [DW-1:0]        d2;
  logic signed [WW-1:0] wd2, hd2;
  // stage 3: numerators
  logic                 v3, pos3;
  logic signed [NW-1:0] nc3, nr3;
  logic [DW-1:0]        d3;
  logic signed [WW-1:0] wd3, hd3;

  logic [DW-1:0]        dsh;
  logic signed [WW-1:0] nc3w, nr3w, d3w;
  logic                 okc, okr;

  assign dsh = {depth1[CB:0], {INTR_FRAC{1'b0}}};
  assign nc3w = WW'(nc3);
  assign nr3w = WW'(nr3);
  assign d3w = $signed({{(WW-DW){1'b0}}, d3});
  // Truncated quotient lies in [0, size) exactly when -D < num < size*D
  // and size is nonzero; an empty image holds nothing.
  assign okc = (nc3w > -d3w) && (nc3w < wd3) && (wd3 != '0);
  assign okr = (nr3w > -d3w) && (nr3w < hd3) && (hd3 != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      ctl <= '0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      ctl.valid <= v3;
      ctl.ok <= v3 & pos3 & okc & okr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      depth1 <= (CB+1)'(px) + (CB+1)'(off_dep);
      horiz1 <= (CB+1)'(off_lat) - (CB+1)'(py);
      vert1  <= (CB+1)'(off_ver) - (CB+1)'(pz);

      pos2 <= depth1 > 0;
      pfc <= $signed({1'b0, focal}) * horiz1;
      pcc <= $signed({1'b0, cen_c}) * depth1;
      pfr <= $signed({1'b0, focal}) * vert1;
      pcr <= $signed({1'b0, cen_r}) * depth1;
      d2 <= dsh;
      wd2 <= $signed({1'b0, img_w}) * $signed({1'b0, dsh});
      hd2 <= $signed({1'b0, img_h}) * $signed({1'b0, dsh});

      pos3 <= pos2;
      nc3 <= NW'(pfc) + NW'(pcc);
      nr3 <= NW'(pfr) + NW'(pcr);
      d3 <= d2;
      wd3 <= wd2;
      hd3 <= hd2;

      // clamp negative numerators: their quotient is zero when in view
      num_c <= nc3[NW-1] ? '0 : nc3[NW-2:0];
      num_r <= nr3[NW-1] ? '0 : nr3[NW-2:0];
      dv <= d3;
    end
  end

endmodule
`default_nettype wire

// ===== design/lpcp_cell.sv =====
// One restoring division cell: settles one quotient bit for column and row.
`default_nettype none
module lpcp_cell
  import lpcp_pkg::*;
#(
  parameter int PB = 13,
  parameter int K  = 12,
  parameter int NW = 51,
  parameter int DW = 33
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire lpcp_ctl_t      ctl_in,
  input  wire logic [NW-2:0]  rc_in,
  input  wire logic [NW-2:0]  rr_in,
  input  wire logic [DW-1:0]  dv_in,
  input  wire logic [PB-1:0]  qc_in,
  input  wire logic [PB-1:0]  qr_in,
  output lpcp_ctl_t           ctl_out,
  output logic [NW-2:0]       rc_out,
  output logic [NW-2:0]       rr_out,
  output logic [DW-1:0]       dv_out,
  output logic [PB-1:0]       qc_out,
  output logic [PB-1:0]       qr_out
);

  localparam int CW = NW + PB + DW;

  logic [CW-1:0] dk, rcw, rrw;
  logic          gc, gr;

  assign dk  = CW'(dv_in) << K;
  assign rcw = CW'(rc_in);
  assign rrw = CW'(rr_in);
  assign gc  = rcw >= dk;
  assign gr  = rrw >= dk;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rc_out <= gc ? (NW-1)'(rcw - dk) : rc_in;
      rr_out <= gr ? (NW-1)'(rrw - dk) : rr_in;
      dv_out <= dv_in;
      qc_out <= qc_in | (PB'(gc) << K);
      qr_out <= qr_in | (PB'(gr) << K);
    end
  end

endmodule
`default_nettype wire

// ===== design/lidar_point_camera_projection.sv =====
// Top level of the lidar point to camera pixel projector.
//
//  channel  direction  handshake                payload
//  s_*      in         s_tvalid / s_tready      tdata: point_x, point_y, point_z
//  m_*      out        m_tvalid / m_tready      tdata: pixel_col, pixel_row; tuser: in_view
//  cfg_*    in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One point per cycle is accepted while the skid register is empty. A point passes
// through 4 front stages, PIXEL_BITS division cells and the output register.
// Reset is synchronous and clears only valid flags; registers take defaults.
// The pipeline advances as a whole; a skid register behind the output
// register holds one extra result, so input stalls only when both are full.
`default_nettype none
module lidar_point_camera_projection
  import lpcp_pkg::*;
#(
  parameter int COORD_BITS = 24,
  parameter int PIXEL_BITS = 13,
  localparam int CFG_BITS = (COORD_BITS > INTR_BITS) ? COORD_BITS : INTR_BITS,
  localparam int IN_BITS = ((3 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = ((2 * PIXEL_BITS + 7) / 8) * 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [IN_BITS-1:0]        s_tdata,  // point_x, point_y, point_z
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [OUT_BITS-1:0]            m_tdata,  // pixel_col, pixel_row
  output logic                           m_tuser,  // in_view
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]       cfg_data
);

  localparam int CB = COORD_BITS;
  localparam int PB = PIXEL_BITS;
  localparam int NW = INTR_BITS + CB + 3;
  localparam int DW = CB + 1 + INTR_FRAC;
  localparam int WW = NW + PB + 1;

  // configuration registers
  logic [INTR_BITS-1:0] focal, cen_c, cen_r;
  logic signed [CB-1:0] off_lat, off_dep, off_ver;
  logic [PB-1:0]        img_w, img_h;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal   <= INTR_BITS'(239439);
      cen_c   <= INTR_BITS'(245760);
      cen_r   <= INTR_BITS'(138240);
      off_lat <= CB'(1536);
      off_dep <= -CB'(307);
      off_ver <= '0;
      img_w   <= PB'(1920);
      img_h   <= PB'(1080);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FOCAL:    focal   <= cfg_data[INTR_BITS-1:0];
        REG_CENTER_C: cen_c   <= cfg_data[INTR_BITS-1:0];
        REG_CENTER_R: cen_r   <= cfg_data[INTR_BITS-1:0];
        REG_LATERAL:  off_lat <= cfg_data[CB-1:0];
        REG_DEPTH:    off_dep <= cfg_data[CB-1:0];
        REG_VERTICAL: off_ver <= cfg_data[CB-1:0];
        REG_WIDTH:    img_w   <= cfg_data[PB-1:0];
        REG_HEIGHT:   img_h   <= cfg_data[PB-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // output register and skid stage
  logic           skid_v;
  logic [PB-1:0]  skid_c, skid_r;
  logic           skid_ok;
  logic           en;

  assign en = !skid_v;
  assign s_tready = en;

  // front stages
  lpcp_ctl_t      f_ctl;
  logic [NW-2:0]  f_nc, f_nr;
  logic [DW-1:0]  f_dv;

  lpcp_front #(.CB(CB), .PB(PB), .NW(NW), .DW(DW), .WW(WW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .px       (s_tdata[CB-1:0]),
    .py       (s_tdata[2*CB-1:CB]),
    .pz       (s_tdata[3*CB-1:2*CB]),
    .focal    (focal),
    .cen_c    (cen_c),
    .cen_r    (cen_r),
    .off_lat  (off_lat),
    .off_dep  (off_dep),
    .off_ver  (off_ver),
    .img_w    (img_w),
    .img_h    (img_h),
    .ctl      (f_ctl),
    .num_c    (f_nc),
    .num_r    (f_nr),
    .dv       (f_dv)
  );

  // division chain: cell i settles quotient bit PB-1-i
  lpcp_ctl_t      c_ctl [PB+1];
  logic [NW-2:0]  c_rc  [PB+1];
  logic [NW-2:0]  c_rr  [PB+1];
  logic [DW-1:0]  c_dv  [PB+1];
  logic [PB-1:0]  c_qc  [PB+1];
  logic [PB-1:0]  c_qr  [PB+1];

  assign c_ctl[0] = f_ctl;
  assign c_rc[0]  = f_nc;
  assign c_rr[0]  = f_nr;
  assign c_dv[0]  = f_dv;
  assign c_qc[0]  = '0;
  assign c_qr[0]  = '0;

  for (genvar i = 0; i < PB; i++) begin : g_cell
    lpcp_cell #(.PB(PB), .K(PB - 1 - i), .NW(NW), .DW(DW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (c_ctl[i]),
      .rc_in   (c_rc[i]),
      .rr_in   (c_rr[i]),
      .dv_in   (c_dv[i]),
      .qc_in   (c_qc[i]),
      .qr_in   (c_qr[i]),
      .ctl_out (c_ctl[i+1]),
      .rc_out  (c_rc[i+1]),
      .rr_out  (c_rr[i+1]),
      .dv_out  (c_dv[i+1]),
      .qc_out  (c_qc[i+1]),
      .qr_out  (c_qr[i+1])
    );
  end

  lpcp_ctl_t     p_ctl;
  logic [PB-1:0] p_c, p_r;

  assign p_ctl = c_ctl[PB];
  // force out-of-view results to zero
  assign p_c = p_ctl.ok ? c_qc[PB] : '0;
  assign p_r = p_ctl.ok ? c_qr[PB] : '0;

  logic [PB-1:0] m_c, m_r;

  assign m_tdata = OUT_BITS'({m_r, m_c});

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (skid_v) begin
          skid_v <= 1'b0;
        end else begin
          m_tvalid <= 1'b0;
        end
      end
      if (en && p_ctl.valid) begin
        if (!m_tvalid || m_tready) begin
          m_tvalid <= 1'b1;
        end else begin
          skid_v <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (m_tvalid && m_tready && skid_v) begin
      m_c <= skid_c;
      m_r <= skid_r;
      m_tuser <= skid_ok;
    end
    if (en && p_ctl.valid) begin
      if (!m_tvalid || m_tready) begin
        m_c <= p_c;
        m_r <= p_r;
        m_tuser <= p_ctl.ok;
      end else begin
        skid_c <= p_c;
        skid_r <= p_r;
        skid_ok <= p_ctl.ok;
      end
    end
  end

  // a held skid result always sits behind a valid output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> m_tvalid) else $error("skid holds data while output is empty");

  // out-of-view results carry zero coordinates
  a_zero_when_out: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_c == '0 && m_r == '0))
    else $error("out-of-view result has nonzero pixel");

  // in-view results lie inside the image
  a_inside_image: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_c < img_w && m_r < img_h))
    else $error("in-view result outside image bounds");

endmodule
`default_nettype wire
